// ===== design/thermocouple_bank_poll_sequencer_unit_defines.svh =====
// Assertion macros for the thermocouple bank poll sequencer.
`ifndef THERMOCOUPLE_BANK_POLL_SEQUENCER_UNIT_DEFINES_SVH
`define THERMOCOUPLE_BANK_POLL_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define TBPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tbps_pkg.sv =====
// Types and constants of the thermocouple bank poll sequencer.
`default_nettype none

package tbps_pkg;

   // channel count default and fixed field widths
   localparam int CHANNELS_DEF = 4;
   localparam int CJ_W         = 14;
   localparam int TC_W         = 19;
   localparam int FLAGS_W      = 4;
   localparam int CSN_W        = 4;
   localparam int TIME_W       = 32;
   localparam int MS_W         = 16;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 56;
   localparam int CSR_IDX_W    = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_OK_MASK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL  = 2'd2;

   // register reset values
   localparam logic [3:0]      LINK_OK_MASK_RST = 4'hF;
   localparam logic [MS_W-1:0] SAMPLE_TIMEOUT_RST = 16'd10;
   localparam logic [MS_W-1:0] POLL_INTERVAL_RST  = 16'd100;

   // device status byte bits that are reported as flags
   localparam int STATUS_OPEN_BIT  = 0;   // 0x01
   localparam int STATUS_OVUV_BIT  = 1;   // 0x02
   localparam int STATUS_TCRNG_BIT = 6;   // 0x40
   localparam int STATUS_CJRNG_BIT = 7;   // 0x80

   // channel condition codes
   localparam logic [1:0] CH_UNKNOWN = 2'd0;
   localparam logic [1:0] CH_ACTIVE  = 2'd1;
   localparam logic [1:0] CH_FAULTED = 2'd2;

   // what a word does to the channel record
   typedef enum logic [1:0] {
      OP_NONE,
      OP_DECODE,
      OP_TIMEOUT
   } op_type;

   // one channel record as held in the record memory
   typedef struct packed {
      logic [CJ_W-1:0]    cj_code;
      logic [TC_W-1:0]    tc_code;
      logic [FLAGS_W-1:0] flags;
      logic               fresh;
      logic [1:0]         state;
   } rec_type;

endpackage

`default_nettype wire

// ===== design/thermocouple_bank_poll_sequencer_unit.sv =====
// Thermocouple bank poll sequencer: top level with channel record memory.
//
// One req word is one service tick: time stamp, bus start acceptance, frame
// completion and the six frame bytes. Every accepted word yields exactly one
// rsp word with the chip selects, the tick's strobes and the record of the
// channel served in that tick, after any update made by that tick.
// Sequencing state (in-flight flag, channel, start and round times) sits in
// registers and is updated as the word is accepted. Channel records sit in a
// one-port-write, registered-read memory: the record is read on acceptance,
// merged in the next cycle (with a bypass of the write made on the acceptance
// edge) and written back as the word moves to the rsp register.
// An accepted word passes from the merge stage register to the rsp register.
// Throughput: one word per cycle while rsp is not stalled; the record
// read-merge-write pipeline and its bypass register let consecutive ticks
// hit the same channel. When rsp is stalled the merge stage still takes one
// more word, then req_tready drops until rsp_tready returns.
// Reset clears the sequencing state, restores the registers to their reset
// values and marks every record as unwritten, so it reads as zero.
// The csr channel is always ready; write only while the block is idle.
`default_nettype none
`include "thermocouple_bank_poll_sequencer_unit_defines.svh"

module thermocouple_bank_poll_sequencer_unit #(
   parameter int CHANNELS = tbps_pkg::CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata, from bit 0: now_ms[31:0], read_accepted, frame_ready,
   // cj_high_byte, cj_low_byte, tc_high_byte, tc_mid_byte, tc_low_byte,
   // fault_status_byte, zero fill
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [tbps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata, from bit 0: chip_select_n[3:0], read_issued, record_updated,
   // channel[1:0], channel_state[1:0], cj_temp[13:0],
   // tc_temp[18:0], fault_flags[3:0], link_up, fresh, zero fill
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [tbps_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tbps_pkg::MS_W-1:0]           csr_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // merge stage contents
   typedef struct packed {
      logic [CH_W-1:0]              ch;
      tbps_pkg::op_type             op;
      logic [tbps_pkg::CJ_W-1:0]    cj_code;
      logic [tbps_pkg::TC_W-1:0]    tc_code;
      logic [tbps_pkg::FLAGS_W-1:0] flags;
      logic                         faulted;
      logic [tbps_pkg::CSN_W-1:0]   csn;
      logic                         issued;
      logic                         link_up;
   } stage_type;

   // configuration registers
   logic [3:0]                  link_mask_ff;
   logic [tbps_pkg::MS_W-1:0]   timeout_ff;
   logic [tbps_pkg::MS_W-1:0]   interval_ff;

   // sequencing state
   logic                        in_flight_ff, in_flight_in;
   logic [CH_W-1:0]             cur_ch_ff, cur_ch_in;
   logic [tbps_pkg::TIME_W-1:0] start_time_ff, start_time_in;
   logic [tbps_pkg::TIME_W-1:0] next_round_ff, next_round_in;

   // pipeline
   logic                        s1_vld_ff;
   stage_type                   s1_ff, s1_in;
   logic                        rsp_vld_ff;
   logic [tbps_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // record memory, its valid bits and write bypass
   tbps_pkg::rec_type           rec_mem [CHANNELS];
   tbps_pkg::rec_type           rd_data_ff;
   logic [CHANNELS-1:0]         rec_vld_ff;
   logic                        fwd_vld_ff;
   logic [CH_W-1:0]             fwd_addr_ff;
   tbps_pkg::rec_type           fwd_data_ff;

   logic                        accept;
   logic                        s1_adv;
   logic                        wr_en;
   tbps_pkg::rec_type           base_rec;
   tbps_pkg::rec_type           new_rec;

   // request fields
   logic [tbps_pkg::TIME_W-1:0] now_ms;
   logic                        read_accepted;
   logic                        frame_ready;
   logic [15:0]                 cj_raw;
   logic [23:0]                 tc_raw;
   logic [7:0]                  status;
   logic [3:0]                  cur_ch4;
   logic                        link_bit;
   logic                        last_ch;
   logic                        round_due;
   logic                        timed_out;
   logic [tbps_pkg::TIME_W-1:0] elapsed;

   assign now_ms        = req_tdata[31:0];
   assign read_accepted = req_tdata[32];
   assign frame_ready   = req_tdata[33];
   assign cj_raw        = {req_tdata[41:34], req_tdata[49:42]};
   assign tc_raw        = {req_tdata[57:50], req_tdata[65:58], req_tdata[73:66]};
   assign status        = req_tdata[81:74];

   // handshakes
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // tick decision from the sequencing state
   assign cur_ch4   = 4'(cur_ch_ff);
   assign link_bit  = (cur_ch4 < 4'd4) ? link_mask_ff[cur_ch4[1:0]] : 1'b0;
   assign last_ch   = (32'(cur_ch_ff) + 32'd1) >= 32'(CHANNELS);
   assign round_due = (cur_ch_ff != '0) || (now_ms >= next_round_ff);
   assign elapsed   = now_ms - start_time_ff;
   assign timed_out = elapsed >= {16'd0, timeout_ff};

   always_comb begin
      in_flight_in  = in_flight_ff;
      cur_ch_in     = cur_ch_ff;
      start_time_in = start_time_ff;
      next_round_in = next_round_ff;
      s1_in.ch       = cur_ch_ff;
      s1_in.op       = tbps_pkg::OP_NONE;
      s1_in.cj_code  = cj_raw[15:2];
      s1_in.tc_code  = tc_raw[23:5];
      s1_in.flags    = {status[tbps_pkg::STATUS_CJRNG_BIT], status[tbps_pkg::STATUS_TCRNG_BIT],
                        status[tbps_pkg::STATUS_OVUV_BIT], status[tbps_pkg::STATUS_OPEN_BIT]};
      s1_in.faulted  = (status != 8'd0) || !link_bit;
      s1_in.issued   = 1'b0;
      s1_in.link_up  = link_bit;
      if (in_flight_ff) begin
         if (frame_ready) begin
            s1_in.op = tbps_pkg::OP_DECODE;
         end else if (timed_out) begin
            s1_in.op = tbps_pkg::OP_TIMEOUT;
         end
         // a finished channel hands over at once; the last one paces the round
         if (frame_ready || timed_out) begin
            in_flight_in = 1'b0;
            if (last_ch) begin
               cur_ch_in     = '0;
               next_round_in = now_ms + {16'd0, interval_ff};
            end else begin
               cur_ch_in = cur_ch_ff + CH_W'(1);
            end
         end
      end else if (round_due) begin
         s1_in.issued = 1'b1;
         if (read_accepted) begin
            start_time_in = now_ms;
            in_flight_in  = 1'b1;
         end
      end
      s1_in.csn = in_flight_in ? ~(4'b0001 << cur_ch4) : 4'hF;
   end

   // configuration writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         link_mask_ff <= tbps_pkg::LINK_OK_MASK_RST;
         timeout_ff   <= tbps_pkg::SAMPLE_TIMEOUT_RST;
         interval_ff  <= tbps_pkg::POLL_INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbps_pkg::CSR_LINK_OK_MASK:   link_mask_ff <= csr_data[3:0];
            tbps_pkg::CSR_SAMPLE_TIMEOUT: timeout_ff   <= csr_data;
            tbps_pkg::CSR_POLL_INTERVAL:  interval_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencing state and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff  <= 1'b0;
         cur_ch_ff     <= '0;
         start_time_ff <= '0;
         next_round_ff <= '0;
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (accept) begin
            in_flight_ff  <= in_flight_in;
            cur_ch_ff     <= cur_ch_in;
            start_time_ff <= start_time_in;
            next_round_ff <= next_round_in;
         end
         if (req_tready) begin
            s1_vld_ff <= req_tvalid;
         end
         if (s1_adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // merge stage payload and record read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         rd_data_ff <= rec_mem[cur_ch_ff];
      end
   end

   // pick the freshest copy of the record, then apply the tick's update
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_ff.ch)) begin
         base_rec = fwd_data_ff;
      end else if (rec_vld_ff[s1_ff.ch]) begin
         base_rec = rd_data_ff;
      end else begin
         base_rec = '0;
      end
      new_rec = base_rec;
      case (s1_ff.op)
         tbps_pkg::OP_DECODE: begin
            new_rec.cj_code = s1_ff.cj_code;
            new_rec.tc_code = s1_ff.tc_code;
            new_rec.flags   = s1_ff.flags;
            new_rec.fresh   = !s1_ff.faulted;
            new_rec.state   = s1_ff.faulted ? tbps_pkg::CH_FAULTED : tbps_pkg::CH_ACTIVE;
         end
         tbps_pkg::OP_TIMEOUT: begin
            new_rec.fresh = 1'b0;
            new_rec.state = tbps_pkg::CH_FAULTED;
         end
         default: ;
      endcase
   end

   assign wr_en = s1_adv && (s1_ff.op != tbps_pkg::OP_NONE);

   // record write-back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[s1_ff.ch] <= new_rec;
      end
   end

   // written-entry marks and bypass of the latest write
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_vld_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (wr_en) begin
         rec_vld_ff[s1_ff.ch] <= 1'b1;
         fwd_vld_ff           <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= s1_ff.ch;
         fwd_data_ff <= new_rec;
      end
   end

   // result word
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[3:0]   = s1_ff.csn;
      rsp_data_in[4]     = s1_ff.issued;
      rsp_data_in[5]     = (s1_ff.op != tbps_pkg::OP_NONE);
      rsp_data_in[7:6]   = 2'(s1_ff.ch);
      rsp_data_in[9:8]   = new_rec.state;
      rsp_data_in[23:10] = new_rec.cj_code;
      rsp_data_in[42:24] = new_rec.tc_code;
      rsp_data_in[46:43] = new_rec.flags;
      rsp_data_in[47]    = s1_ff.link_up;
      rsp_data_in[48]    = new_rec.fresh;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   `TBPS_ASSERT_NOW(a_ch_range, 1'b1, 32'(cur_ch_ff) < CHANNELS, "channel out of range")
   `TBPS_ASSERT_NEXT(a_fwd_tracks_write, wr_en,
      fwd_vld_ff && (fwd_addr_ff == $past(s1_ff.ch)), "bypass missed record write")
   `TBPS_ASSERT_NOW(a_update_ends_read, rsp_vld_ff && rsp_data_ff[5],
      (rsp_data_ff[3:0] == 4'hF) && !rsp_data_ff[4], "record update with select held")

endmodule

`default_nettype wire
